@@ hw/rtl/line_sensor_calibrate_centroid_macros.svh @@
// Assertion macros shared by the line sensor calibrate/centroid RTL.
`ifndef LINE_SENSOR_CALIBRATE_CENTROID_MACROS_SVH
`define LINE_SENSOR_CALIBRATE_CENTROID_MACROS_SVH

// Same-cycle implication, checked on clk, disabled during reset.
`define LSCC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, disabled during reset.
`define LSCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/lscc_pkg.sv @@
// Shared constants, codes and types of the line sensor calibrate/centroid block.
package lscc_pkg;

    localparam int LINE_CHANNELS_DEF = 10;
    localparam int SAMPLE_BITS_DEF   = 12;

    localparam int CH_W       = 4;
    localparam int SAMPLE_W   = 12;
    localparam int LEVEL_W    = 16;
    localparam int LEVEL_FRAC = 14;
    localparam int WEIGHT_W   = 16;
    localparam int STATUS_W   = 2;

    // weight_first + i*weight_step for i up to 15 stays below 2^20
    localparam int WGT_FULL_W = 21;
    localparam int PROD_W     = WGT_FULL_W + LEVEL_W;
    localparam int NUM_ACC_W  = PROD_W + 2;
    localparam int DEN_ACC_W  = LEVEL_W + 2;

    // divider: magnitudes only, two quotient bits per cycle
    localparam int DIV_NUM_W = 36;
    localparam int DIV_DEN_W = 17;
    localparam int DIV_DIGIT = 2;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic signed [WEIGHT_W-1:0] WEIGHT_FIRST_RST = -16'sd4500;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_STEP_RST  = 16'sd1000;

    localparam logic REG_WEIGHT_FIRST = 1'b0;
    localparam logic REG_WEIGHT_STEP  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SPAN     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_SUM = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNUSED   = 2'd3;

    localparam logic MODE_CALIBRATE = 1'b0;

    typedef struct packed {
        logic                 start;
        logic                 num_neg;
        logic [DIV_NUM_W-1:0] num_mag;
        logic                 den_neg;
        logic [DIV_DEN_W-1:0] den_mag;
    } div_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [LEVEL_W-1:0] quot;
    } div_rsp_t;

endpackage

@@ hw/rtl/line_sensor_calibrate_centroid.sv @@
// Line sensor min/max calibration, normalization, peak search and peak-window centroid.
//
// A calibrate item updates its channel's minimum and maximum. A measure item on a valid
// channel runs the shared divider, which retires two quotient bits per cycle over a
// 36-bit dividend, with the start, saturation, done and level store write steps around
// it; a channel whose span is zero skips the divider. An item with the last mark in
// measure mode sets the window bounds, reads, multiplies and accumulates each window
// entry (two entries when the peak sits at an end of the line) through the level RAM and
// the 21x16 multiplier, reads the corner and goal levels, runs the centroid divider pass
// and loads the output register once it is free; a zero level sum skips the divider
// pass. The block takes the next item while a result still waits in the output register;
// a new result waits until that register is free.
`include "line_sensor_calibrate_centroid_macros.svh"

module line_sensor_calibrate_centroid #(
    parameter int LINE_CHANNELS = lscc_pkg::LINE_CHANNELS_DEF,
    parameter int SAMPLE_BITS   = lscc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata: channel[3:0], sample[15:4]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lscc_pkg::IN_TDATA_W-1:0]     s_tdata,
    // s_tuser: mode
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    // m_tdata: angle[15:0], corner_level[31:16], goal_level[47:32],
    //          peak_channel[51:48], status[53:52], zero[55:54]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lscc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lscc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [lscc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [lscc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int ALL  = LINE_CHANNELS + 2;
    localparam int AW   = $clog2(ALL);
    localparam int CW   = lscc_pkg::CH_W;
    localparam int SB   = SAMPLE_BITS;
    localparam int LW   = lscc_pkg::LEVEL_W;
    localparam int WW   = lscc_pkg::WEIGHT_W;
    localparam int FW   = lscc_pkg::WGT_FULL_W;
    localparam int PW   = lscc_pkg::PROD_W;
    localparam int NAW  = lscc_pkg::NUM_ACC_W;
    localparam int DAW  = lscc_pkg::DEN_ACC_W;
    localparam int SW   = lscc_pkg::STATUS_W;

    localparam logic [CW:0]   ALL_C   = (CW + 1)'(ALL);
    localparam logic [CW:0]   LINE_C  = (CW + 1)'(LINE_CHANNELS);
    localparam logic [CW-1:0] LINE_M1 = CW'(LINE_CHANNELS - 1);
    localparam logic [AW-1:0] CORNER_A = AW'(LINE_CHANNELS);
    localparam logic [AW-1:0] GOAL_A   = AW'(LINE_CHANNELS + 1);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] ST_CAL   = 4'd1;
    localparam logic [ST_W-1:0] ST_NORM  = 4'd2;
    localparam logic [ST_W-1:0] ST_NWAIT = 4'd3;
    localparam logic [ST_W-1:0] ST_STORE = 4'd4;
    localparam logic [ST_W-1:0] ST_WIN   = 4'd5;
    localparam logic [ST_W-1:0] ST_RD    = 4'd6;
    localparam logic [ST_W-1:0] ST_MUL   = 4'd7;
    localparam logic [ST_W-1:0] ST_ACC   = 4'd8;
    localparam logic [ST_W-1:0] ST_CRD   = 4'd9;
    localparam logic [ST_W-1:0] ST_GRD   = 4'd10;
    localparam logic [ST_W-1:0] ST_GCAP  = 4'd11;
    localparam logic [ST_W-1:0] ST_CENT  = 4'd12;
    localparam logic [ST_W-1:0] ST_CWAIT = 4'd13;
    localparam logic [ST_W-1:0] ST_OUT   = 4'd14;

    // configuration
    logic signed [WW-1:0] wfirst_reg, wstep_reg;

    // control
    logic [ST_W-1:0] state_reg, state_next;
    logic            span_err_reg, span_err_next;
    logic [CW-1:0]   peak_idx_reg, peak_idx_next;
    logic signed [LW-1:0] peak_lvl_reg, peak_lvl_next;
    logic            m_tvalid_reg, m_tvalid_next;

    // payload
    logic            last_reg;
    logic [CW-1:0]   ch_reg;
    logic [SB-1:0]   smp_reg;
    logic [SB-1:0]   cal_min_reg [ALL];
    logic [SB-1:0]   cal_max_reg [ALL];
    logic signed [LW-1:0]  lvl_reg, lvl_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         hi_reg, hi_next;
    logic signed [FW-1:0]  w_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [NAW-1:0] num_reg, num_next;
    logic signed [DAW-1:0] den_reg, den_next;
    logic signed [LW-1:0]  corner_reg, goal_reg, angle_reg, angle_next;
    logic [SW-1:0]         status_reg, status_next;
    logic [lscc_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    logic            accept;
    logic            ch_ok, ch_line;
    logic [AW-1:0]   ch_idx;
    logic [SB-1:0]   cmin, cmax;
    logic signed [SB:0] diff, span;
    logic [SB-1:0]   diff_abs, span_abs;
    logic signed [NAW-1:0] num_abs;
    logic signed [DAW-1:0] den_abs;
    logic signed [FW-1:0]  w_next;

    logic            ram_we;
    logic [AW-1:0]   ram_raddr;
    logic [LW-1:0]   ram_rdata;

    lscc_pkg::div_req_t div_req;
    lscc_pkg::div_rsp_t div_rsp;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign ch_ok    = ({1'b0, ch_reg} < ALL_C);
    assign ch_line  = ({1'b0, ch_reg} < LINE_C);
    assign ch_idx   = AW'(ch_reg);
    assign cmin     = cal_min_reg[ch_idx];
    assign cmax     = cal_max_reg[ch_idx];

    // configuration port
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            lscc_pkg::REG_WEIGHT_FIRST: prdata = {{(32 - WW){1'b0}}, wfirst_reg};
            lscc_pkg::REG_WEIGHT_STEP:  prdata = {{(32 - WW){1'b0}}, wstep_reg};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wfirst_reg <= lscc_pkg::WEIGHT_FIRST_RST;
            wstep_reg  <= lscc_pkg::WEIGHT_STEP_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[2])
                lscc_pkg::REG_WEIGHT_FIRST: wfirst_reg <= $signed(pwdata[WW-1:0]);
                lscc_pkg::REG_WEIGHT_STEP:  wstep_reg  <= $signed(pwdata[WW-1:0]);
                default:                    wfirst_reg <= wfirst_reg;
            endcase
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= s_tlast;
            ch_reg   <= s_tdata[CW-1:0];
            smp_reg  <= SB'(s_tdata[CW +: lscc_pkg::SAMPLE_W]);
        end
    end

    // calibration tables, full scale minimum and zero maximum after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALL; i++)
            begin
                cal_min_reg[i] <= '1;
                cal_max_reg[i] <= '0;
            end
        end
        else if (state_reg == ST_CAL && ch_ok)
        begin
            if (smp_reg > cmax)
            begin
                cal_max_reg[ch_idx] <= smp_reg;
            end
            if (smp_reg < cmin)
            begin
                cal_min_reg[ch_idx] <= smp_reg;
            end
        end
    end

    // normalization and centroid divider operands
    always_comb
    begin
        diff     = $signed({1'b0, smp_reg}) - $signed({1'b0, cmin});
        span     = $signed({1'b0, cmax}) - $signed({1'b0, cmin});
        diff_abs = diff[SB] ? SB'(-diff) : diff[SB-1:0];
        span_abs = span[SB] ? SB'(-span) : span[SB-1:0];
        num_abs  = num_reg[NAW-1] ? -num_reg : num_reg;
        den_abs  = den_reg[DAW-1] ? -den_reg : den_reg;
    end

    always_comb
    begin
        div_req = '0;
        if (state_reg == ST_NORM)
        begin
            div_req.start   = (span != '0);
            div_req.num_neg = diff[SB];
            div_req.num_mag = lscc_pkg::DIV_NUM_W'(diff_abs) << lscc_pkg::LEVEL_FRAC;
            div_req.den_neg = span[SB];
            div_req.den_mag = lscc_pkg::DIV_DEN_W'(span_abs);
        end
        else if (state_reg == ST_CENT)
        begin
            div_req.start   = (den_reg != '0);
            div_req.num_neg = num_reg[NAW-1];
            div_req.num_mag = lscc_pkg::DIV_NUM_W'(num_abs);
            div_req.den_neg = den_reg[DAW-1];
            div_req.den_mag = lscc_pkg::DIV_DEN_W'(den_abs);
        end
    end

    lscc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign ram_we = (state_reg == ST_STORE);

    always_comb
    begin
        case (state_reg)
            ST_CRD:  ram_raddr = CORNER_A;
            ST_GRD:  ram_raddr = GOAL_A;
            default: ram_raddr = AW'(idx_reg);
        endcase
    end

    lscc_ram #(
        .WIDTH (LW),
        .DEPTH (ALL)
    ) u_level_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ch_idx),
        .wdata (lvl_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // position weight of the current window entry
    assign w_next = FW'(wfirst_reg) + FW'($signed({1'b0, idx_reg})) * FW'(wstep_reg);

    always_comb
    begin
        state_next    = state_reg;
        span_err_next = span_err_reg;
        peak_idx_next = peak_idx_reg;
        peak_lvl_next = peak_lvl_reg;
        m_tvalid_next = m_tvalid_reg;
        lvl_next      = lvl_reg;
        idx_next      = idx_reg;
        hi_next       = hi_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        angle_next    = angle_reg;
        status_next   = status_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == lscc_pkg::MODE_CALIBRATE)
                    begin
                        state_next = ST_CAL;
                    end
                    else if ({1'b0, s_tdata[CW-1:0]} < ALL_C)
                    begin
                        state_next = ST_NORM;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_WIN;
                    end
                end
            end
            ST_CAL:
            begin
                state_next = ST_IDLE;
            end
            ST_NORM:
            begin
                if (span == '0)
                begin
                    lvl_next      = '0;
                    span_err_next = 1'b1;
                    state_next    = ST_STORE;
                end
                else
                begin
                    state_next = ST_NWAIT;
                end
            end
            ST_NWAIT:
            begin
                if (div_rsp.done)
                begin
                    lvl_next   = div_rsp.quot;
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                // channel zero restarts the first-maximum search
                if (ch_reg == '0)
                begin
                    peak_idx_next = '0;
                    peak_lvl_next = lvl_reg;
                end
                else if (ch_line && lvl_reg > peak_lvl_reg)
                begin
                    peak_idx_next = ch_reg;
                    peak_lvl_next = lvl_reg;
                end
                state_next = last_reg ? ST_WIN : ST_IDLE;
            end
            ST_WIN:
            begin
                idx_next   = (peak_idx_reg != '0) ? CW'(peak_idx_reg - 1'b1) : '0;
                hi_next    = (({1'b0, peak_idx_reg} + 1'b1) < LINE_C)
                             ? CW'(peak_idx_reg + 1'b1) : LINE_M1;
                num_next   = '0;
                den_next   = '0;
                state_next = ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                lvl_next   = $signed(ram_rdata);
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                num_next = num_reg + NAW'(prod_reg);
                den_next = den_reg + DAW'(lvl_reg);
                if (idx_reg == hi_reg)
                begin
                    state_next = ST_CRD;
                end
                else
                begin
                    idx_next   = CW'(idx_reg + 1'b1);
                    state_next = ST_RD;
                end
            end
            ST_CRD:
            begin
                state_next = ST_GRD;
            end
            ST_GRD:
            begin
                state_next = ST_GCAP;
            end
            ST_GCAP:
            begin
                state_next = ST_CENT;
            end
            ST_CENT:
            begin
                if (den_reg == '0)
                begin
                    angle_next  = '0;
                    status_next = lscc_pkg::STATUS_ZERO_SUM;
                    state_next  = ST_OUT;
                end
                else
                begin
                    state_next = ST_CWAIT;
                end
            end
            ST_CWAIT:
            begin
                if (div_rsp.done)
                begin
                    angle_next  = div_rsp.quot;
                    status_next = span_err_reg ? lscc_pkg::STATUS_SPAN : lscc_pkg::STATUS_OK;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    span_err_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            span_err_reg <= 1'b0;
            peak_idx_reg <= '0;
            peak_lvl_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            span_err_reg <= span_err_next;
            peak_idx_reg <= peak_idx_next;
            peak_lvl_reg <= peak_lvl_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg    <= lvl_next;
        idx_reg    <= idx_next;
        hi_reg     <= hi_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        angle_reg  <= angle_next;
        status_reg <= status_next;
        w_reg      <= w_next;
        prod_reg   <= w_reg * $signed(ram_rdata);
        if (state_reg == ST_GRD)
        begin
            corner_reg <= $signed(ram_rdata);
        end
        if (state_reg == ST_GCAP)
        begin
            goal_reg <= $signed(ram_rdata);
        end
        if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready))
        begin
            m_tdata_reg <= {2'b00, status_reg, peak_idx_reg, goal_reg, corner_reg, angle_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `LSCC_ASSERT_NEXT(a_out_waits, state_reg == ST_OUT && m_tvalid_reg && !m_tready, state_reg == ST_OUT, "result overwrote a pending transfer")
    `LSCC_ASSERT_IMPL(a_peak_range, 1'b1, {1'b0, peak_idx_reg} < LINE_C, "peak index outside line channels")
    `LSCC_ASSERT_IMPL(a_status_code, m_tvalid_reg, m_tdata_reg[53:52] != lscc_pkg::STATUS_UNUSED, "undefined status code")

endmodule

@@ hw/rtl/lscc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lscc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 12
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/lscc_div.sv @@
// Radix-4 serial signed divider with truncation toward zero and 16-bit saturation.
`include "line_sensor_calibrate_centroid_macros.svh"

module lscc_div (
    input  logic               clk,
    input  logic               rst_n,
    input  lscc_pkg::div_req_t req,
    output lscc_pkg::div_rsp_t rsp
);

    localparam int STEPS = lscc_pkg::DIV_NUM_W / lscc_pkg::DIV_DIGIT;
    localparam int CNT_W = $clog2(STEPS);
    localparam int NW    = lscc_pkg::DIV_NUM_W;
    localparam int DW    = lscc_pkg::DIV_DEN_W;
    localparam int LW    = lscc_pkg::LEVEL_W;
    localparam logic [NW-1:0] POS_MAX = NW'((1 << (LW - 1)) - 1);
    localparam logic [NW-1:0] NEG_MAX = NW'(1 << (LW - 1));

    logic                 busy_reg, busy_next;
    logic                 fin_reg, fin_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DW-1:0]        rem_reg, rem_next;
    logic [DW-1:0]        den_reg, den_next;
    logic [NW-1:0]        quo_reg, quo_next;
    logic                 neg_reg, neg_next;
    logic signed [LW-1:0] quot_reg, quot_next;

    logic [DW:0]   t1, t2;
    logic          ge1, ge2;
    logic [DW-1:0] r1, r2;

    // two restoring steps per cycle
    always_comb
    begin
        t1  = {rem_reg, quo_reg[NW-1]};
        ge1 = (t1 >= {1'b0, den_reg});
        r1  = ge1 ? DW'(t1 - {1'b0, den_reg}) : t1[DW-1:0];
        t2  = {r1, quo_reg[NW-2]};
        ge2 = (t2 >= {1'b0, den_reg});
        r2  = ge2 ? DW'(t2 - {1'b0, den_reg}) : t2[DW-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = req.den_mag;
            quo_next  = req.num_mag;
            neg_next  = req.num_neg ^ req.den_neg;
        end
        else if (busy_reg)
        begin
            rem_next = r2;
            quo_next = {quo_reg[NW-3:0], ge1, ge2};
            cnt_next = CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            done_next = 1'b1;
            if (neg_reg)
            begin
                quot_next = (quo_reg > NEG_MAX) ? $signed(NEG_MAX[LW-1:0])
                                                : $signed(LW'(-quo_reg[LW-1:0]));
            end
            else
            begin
                quot_next = (quo_reg > POS_MAX) ? $signed(POS_MAX[LW-1:0])
                                                : $signed(quo_reg[LW-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    `LSCC_ASSERT_IMPL(a_div_start_idle, req.start, !busy_reg && !fin_reg, "divider restarted while busy")
    `LSCC_ASSERT_IMPL(a_div_done_after_fin, done_reg, $past(fin_reg), "divider done without final step")
    `LSCC_ASSERT_IMPL(a_div_cnt_range, busy_reg, cnt_reg < CNT_W'(STEPS), "divider step count out of range")

endmodule

@@ tb/tb_line_sensor_calibrate_centroid.sv @@
// Self-checking testbench for the line sensor calibrate/centroid block.
module tb_line_sensor_calibrate_centroid;
    import lscc_pkg::*;

    localparam int   LINE_CH      = LINE_CHANNELS_DEF;
    localparam int   ALL_CH       = LINE_CHANNELS_DEF + 2;
    localparam int   CORNER_CH    = LINE_CHANNELS_DEF;
    localparam int   GOAL_CH      = LINE_CHANNELS_DEF + 1;
    localparam logic MODE_MEASURE = ~MODE_CALIBRATE;
    localparam int   ITEMS_PER_PHASE = 200;
    localparam int   PHASES       = 6;

    typedef struct {
        logic signed [LEVEL_W-1:0] angle;
        logic signed [LEVEL_W-1:0] corner;
        logic signed [LEVEL_W-1:0] goal;
        logic [CH_W-1:0]           peak;
        logic [STATUS_W-1:0]       status;
    } scan_result_t;

    class centroid_scoreboard;
        logic [SAMPLE_W-1:0]        cal_min [ALL_CH];
        logic [SAMPLE_W-1:0]        cal_max [ALL_CH];
        logic signed [LEVEL_W-1:0]  levels [ALL_CH];
        logic [CH_W-1:0]            peak_idx;
        logic signed [LEVEL_W-1:0]  peak_lvl;
        bit                         span_err;
        logic signed [WEIGHT_W-1:0] w_first;
        logic signed [WEIGHT_W-1:0] w_step;
        scan_result_t               expected_q[$];
        int                         n_inputs;
        int                         n_results;
        int                         errors;
        int                         status_seen[4];

        function new();
            for (int i = 0; i < ALL_CH; i++)
            begin
                cal_min[i] = '1;
                cal_max[i] = '0;
                levels[i]  = '0;
            end
            peak_idx  = '0;
            peak_lvl  = '0;
            span_err  = 1'b0;
            w_first   = WEIGHT_FIRST_RST;
            w_step    = WEIGHT_STEP_RST;
            n_inputs  = 0;
            n_results = 0;
            errors    = 0;
            for (int i = 0; i < 4; i++)
                status_seen[i] = 0;
        endfunction

        function void set_weight(logic idx, logic signed [WEIGHT_W-1:0] v);
            if (idx == REG_WEIGHT_FIRST)
                w_first = v;
            else
                w_step = v;
        endfunction

        function logic signed [LEVEL_W-1:0] sat16(longint v);
            if (v > 32767)
                return 16'sd32767;
            if (v < -32768)
                return -16'sd32768;
            return v[LEVEL_W-1:0];
        endfunction

        function void mismatch(string field, longint exp_v, longint act_v);
            errors++;
            if (errors <= 10)
                $display("mismatch on %s: expected %0d, got %0d", field, exp_v, act_v);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Accepted input transfer: update the model and queue any scan result.
        function void note_input(logic mode, logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] sample,
                                 logic last);
            longint       span;
            longint       num;
            longint       den;
            longint       w;
            logic signed [LEVEL_W-1:0] lv;
            int           lo;
            int           hi;
            scan_result_t r;
            n_inputs++;
            if (mode == MODE_CALIBRATE)
            begin
                if (ch < ALL_CH)
                begin
                    if (sample > cal_max[ch])
                        cal_max[ch] = sample;
                    if (sample < cal_min[ch])
                        cal_min[ch] = sample;
                end
                return;
            end
            if (ch < ALL_CH)
            begin
                span = longint'(cal_max[ch]) - longint'(cal_min[ch]);
                if (span == 0)
                begin
                    lv = '0;
                    span_err = 1'b1;
                end
                else
                    lv = sat16((longint'(sample) - longint'(cal_min[ch])) * 16384 / span);
                levels[ch] = lv;
                if (ch == 0)
                begin
                    peak_idx = '0;
                    peak_lvl = lv;
                end
                else if (ch < LINE_CH && lv > peak_lvl)
                begin
                    peak_idx = ch;
                    peak_lvl = lv;
                end
            end
            if (!last)
                return;
            lo  = (peak_idx > 0) ? int'(peak_idx) - 1 : 0;
            hi  = (int'(peak_idx) + 1 < LINE_CH) ? int'(peak_idx) + 1 : LINE_CH - 1;
            num = 0;
            den = 0;
            for (int i = lo; i <= hi; i++)
            begin
                w = longint'(w_first) + longint'(i) * longint'(w_step);
                num += w * longint'(levels[i]);
                den += longint'(levels[i]);
            end
            if (den == 0)
            begin
                r.angle  = '0;
                r.status = STATUS_ZERO_SUM;
            end
            else
            begin
                r.angle  = sat16(num / den);
                r.status = span_err ? STATUS_SPAN : STATUS_OK;
            end
            r.corner = levels[CORNER_CH];
            r.goal   = levels[GOAL_CH];
            r.peak   = peak_idx;
            span_err = 1'b0;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d);
            scan_result_t r;
            if (expected_q.size() == 0)
            begin
                mismatch("unexpected result transfer, tdata low bits", 0, d[31:0]);
                return;
            end
            r = expected_q.pop_front();
            n_results++;
            status_seen[r.status]++;
            if (d[15:0] !== r.angle)
                mismatch("angle", r.angle, $signed(d[15:0]));
            if (d[31:16] !== r.corner)
                mismatch("corner_level", r.corner, $signed(d[31:16]));
            if (d[47:32] !== r.goal)
                mismatch("goal_level", r.goal, $signed(d[47:32]));
            if (d[51:48] !== r.peak)
                mismatch("peak_channel", r.peak, d[51:48]);
            if (d[53:52] !== r.status)
                mismatch("status", r.status, d[53:52]);
            if (d[55:54] !== 2'b00)
                mismatch("tdata pad", 0, d[55:54]);
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic                    s_tuser;
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CFG_ADDR_W-1:0]   paddr;
    logic [CFG_DATA_W-1:0]   pwdata;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    centroid_scoreboard sb;
    int items_sent;
    int weight_settings;

    line_sensor_calibrate_centroid dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #6000000;
        $display("tb_line_sensor_calibrate_centroid: errors");
        $finish;
    end

    // One input transfer, with random gaps ahead of it outside the no-gap stretch.
    task automatic send_item(logic mode, logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] sample,
                             logic last);
        while (!(items_sent >= 400 && items_sent < 650) && $urandom_range(0, 99) < 29)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sample, ch};
        s_tuser  <= mode;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(mode, ch, sample, last);
        items_sent++;
    endtask

    // Drain all results, then allow for a measure item still in the divider.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic cfg_write(logic idx, logic signed [WEIGHT_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{16{v[15]}}, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_weight(idx, v);
        @(posedge clk);
    endtask

    task automatic cfg_read_check(logic idx);
        logic signed [WEIGHT_W-1:0] exp_v;
        exp_v   = (idx == REG_WEIGHT_FIRST) ? sb.w_first : sb.w_step;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[15:0] !== exp_v)
            sb.mismatch("register readback", exp_v, $signed(prdata[15:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Result side: random back-pressure, one long hold-off, and a stretch with none.
    initial
    begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (!held && sb.n_results == 12)
            begin
                held      = 1'b1;
                hold_left = 2000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (sb.n_results >= 30 && sb.n_results < 60)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 29);
        end
    end

    initial
    begin
        logic signed [WEIGHT_W-1:0] first_set [PHASES];
        logic signed [WEIGHT_W-1:0] step_set [PHASES];
        int   pick;
        int   stop_ch;
        bit   flat;
        logic [SAMPLE_W-1:0] smp;

        sb = new();
        items_sent      = 0;
        weight_settings = 1;
        first_set = '{-16'sd4500, -16'sd32768, 16'sd32767, 16'sd0, 16'sd32767, 16'sd0};
        step_set  = '{16'sd1000, 16'sd32767, -16'sd32768, 16'sd0, 16'sd32767, 16'sd0};
        first_set[PHASES-1] = WEIGHT_W'($urandom());
        step_set[PHASES-1]  = WEIGHT_W'($urandom());

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cfg_read_check(REG_WEIGHT_FIRST);
        cfg_read_check(REG_WEIGHT_STEP);

        // full measure scan before any calibration: negative spans, every level written
        for (int ch = 0; ch < ALL_CH; ch++)
        begin
            smp = (ch == 0) ? 12'd0 : (ch == 1) ? 12'd4095 : 12'($urandom_range(0, 4095));
            send_item(MODE_MEASURE, CH_W'(ch), smp, ch == ALL_CH - 1);
        end
        // calibrate with last set gives no result; goal gets a single reading
        send_item(MODE_CALIBRATE, CH_W'(GOAL_CH), 12'd2048, 1'b1);
        send_item(MODE_CALIBRATE, 4'd15, 12'd4095, 1'b1);
        send_item(MODE_CALIBRATE, 4'd3, 12'd3000, 1'b0);
        send_item(MODE_CALIBRATE, 4'd3, 12'd3100, 1'b0);
        // normalized level saturates both ways on a narrow span
        send_item(MODE_MEASURE, 4'd3, 12'd4095, 1'b0);
        send_item(MODE_MEASURE, 4'd3, 12'd0, 1'b0);
        send_item(MODE_MEASURE, CH_W'(GOAL_CH), 12'd2048, 1'b0);
        // out-of-range channel still closes the scan
        send_item(MODE_MEASURE, 4'd14, 12'd1234, 1'b1);
        // window of zero levels
        send_item(MODE_MEASURE, 4'd0, 12'd4095, 1'b0);
        send_item(MODE_MEASURE, 4'd1, 12'd4095, 1'b1);
        // peak on the top line channel clips the window
        send_item(MODE_MEASURE, 4'd0, 12'd4095, 1'b0);
        send_item(MODE_MEASURE, CH_W'(LINE_CH - 1), 12'd0, 1'b1);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                settle();
                cfg_write(REG_WEIGHT_FIRST, first_set[ph]);
                cfg_write(REG_WEIGHT_STEP, step_set[ph]);
                cfg_read_check(REG_WEIGHT_FIRST);
                cfg_read_check(REG_WEIGHT_STEP);
                weight_settings++;
            end
            while (items_sent < 24 + (ph + 1) * ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                begin
                    // these sweeps give the goal a fixed reading for the first part of the run
                    for (int ch = 0; ch < ALL_CH; ch++)
                    begin
                        if (ch == GOAL_CH && items_sent < 700)
                            smp = 12'd2048;
                        else
                            smp = SAMPLE_W'($urandom_range(800, 3200));
                        send_item(MODE_CALIBRATE, CH_W'(ch), smp, ch == ALL_CH - 1);
                    end
                end
                else if (pick < 88)
                begin
                    flat    = ($urandom_range(0, 7) == 0);
                    stop_ch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, LINE_CH - 1)
                                                          : GOAL_CH;
                    for (int ch = 0; ch <= stop_ch; ch++)
                    begin
                        if (flat && ch < LINE_CH)
                            smp = sb.cal_min[ch];
                        else if ($urandom_range(0, 3) == 0 || sb.cal_min[ch] > sb.cal_max[ch])
                            smp = SAMPLE_W'($urandom_range(0, 4095));
                        else
                            smp = SAMPLE_W'($urandom_range(sb.cal_min[ch], sb.cal_max[ch]));
                        send_item(MODE_MEASURE, CH_W'(ch), smp, ch == stop_ch);
                    end
                end
                else
                begin
                    repeat ($urandom_range(1, 4))
                        send_item(1'($urandom_range(0, 1)), CH_W'($urandom_range(0, 15)),
                                  SAMPLE_W'($urandom()), 1'($urandom_range(0, 1)));
                end
            end
        end

        settle();
        $display("%0d input transfers over %0d weight settings, %0d results",
                 sb.n_inputs, weight_settings, sb.n_results);
        $display("result status: %0d ok, %0d span error, %0d zero sum",
                 sb.status_seen[STATUS_OK], sb.status_seen[STATUS_SPAN],
                 sb.status_seen[STATUS_ZERO_SUM]);
        if (sb.errors == 0)
            $display("tb_line_sensor_calibrate_centroid: clean");
        else
            $display("tb_line_sensor_calibrate_centroid: errors");
        $finish;
    end

endmodule
